// File: hdl/enig_pkg.sv
// Shared constants, command codes and table port types for the rotor cipher.
package enig_pkg;

    localparam int ALPHA           = 26;
    localparam int DEF_ROTOR_COUNT = 3;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_ENCRYPT = 3'd0;
    localparam cmd_t CMD_PLUG    = 3'd1;
    localparam cmd_t CMD_WIRE    = 3'd2;
    localparam cmd_t CMD_REFL    = 3'd3;
    localparam cmd_t CMD_NOTCH   = 3'd4;
    localparam cmd_t CMD_POS     = 3'd5;

    typedef struct packed {
        logic    plug_we;
        letter_t plug_addr;
        letter_t plug_wdata;
        logic    refl_we;
        letter_t refl_addr;
        letter_t refl_wdata;
        logic    wir_we;
        letter_t wir_wdata;
        letter_t wir_contact;
        logic    inv_we;
        letter_t inv_wdata;
        letter_t inv_contact;
        logic    notch_we;
        logic    notch_wdata;
    } enig_tbl_req_t;

    typedef struct packed {
        letter_t plug_rd;
        letter_t refl_rd;
        letter_t wir_rd;
        letter_t inv_rd;
        logic    notch_rd;
    } enig_tbl_rsp_t;

endpackage

// File: hdl/enigma_rotor_cipher.sv
// Top level of the rotor cipher: stream ports, sequencer and table memories.
//
//  channel   dir   tdata                                        tuser
//  s_axis    in    letter, rotor_index, table_index,            command
//                  table_value, notch_flag
//  m_axis    out   cipher_letter                                letter_valid
//
// Encrypt items run through one shared modulo-26 adder and one registered read per
// table pass. Plug and reflector loads write both entries of the pair.
// Reset clears rotor positions; unwritten tables read as identity, notches clear.
// A result waits in the output register; the next item is taken meanwhile.
module enigma_rotor_cipher
#(
    parameter int ROTOR_COUNT = enig_pkg::DEF_ROTOR_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // letter, rotor_index, table_index, table_value, notch_flag
    input  logic [2:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // cipher_letter
    output logic        m_axis_tuser   // letter_valid
);

    localparam int AW = $clog2(ROTOR_COUNT * enig_pkg::ALPHA);

    enig_pkg::enig_tbl_req_t req;
    enig_pkg::enig_tbl_rsp_t rsp;
    logic [AW-1:0]           wir_addr, inv_addr, notch_addr;
    enig_pkg::letter_t       cipher_letter;

    enig_ctrl #(.ROTOR_COUNT(ROTOR_COUNT)) u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .command       (s_axis_tuser),
        .letter        (s_axis_tdata[4:0]),
        .rotor_index   (s_axis_tdata[7:5]),
        .table_index   (s_axis_tdata[12:8]),
        .table_value   (s_axis_tdata[17:13]),
        .notch_flag    (s_axis_tdata[18]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .cipher_letter (cipher_letter),
        .letter_valid  (m_axis_tuser),
        .req           (req),
        .wir_addr      (wir_addr),
        .inv_addr      (inv_addr),
        .notch_addr    (notch_addr),
        .rsp           (rsp)
    );

    enig_tables #(.ROTOR_COUNT(ROTOR_COUNT)) u_tables
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .wir_addr   (wir_addr),
        .inv_addr   (inv_addr),
        .notch_addr (notch_addr),
        .rsp        (rsp)
    );

    assign m_axis_tdata = {3'b000, cipher_letter};

endmodule

// File: hdl/enig_addmod.sv
// Shared modulo-26 adder used for rotor stepping and rotor offsets.
module enig_addmod
(
    input  enig_pkg::letter_t a,
    input  enig_pkg::letter_t b,
    output enig_pkg::letter_t sum
);

    logic [5:0] raw;

    assign raw = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        if (raw >= 6'(enig_pkg::ALPHA))
        begin
            sum = 5'(raw - 6'(enig_pkg::ALPHA));
        end
        else
        begin
            sum = raw[4:0];
        end
    end

endmodule

// File: hdl/enig_tables.sv
// Plugboard, reflector, rotor wiring, inverse and notch memories with registered reads.
module enig_tables
#(
    parameter int ROTOR_COUNT = enig_pkg::DEF_ROTOR_COUNT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  enig_pkg::enig_tbl_req_t      req,
    input  logic [$clog2(ROTOR_COUNT*enig_pkg::ALPHA)-1:0] wir_addr,
    input  logic [$clog2(ROTOR_COUNT*enig_pkg::ALPHA)-1:0] inv_addr,
    input  logic [$clog2(ROTOR_COUNT*enig_pkg::ALPHA)-1:0] notch_addr,
    output enig_pkg::enig_tbl_rsp_t      rsp
);

    localparam int DEPTH = ROTOR_COUNT * enig_pkg::ALPHA;

    enig_pkg::letter_t plug_mem  [enig_pkg::ALPHA];
    enig_pkg::letter_t refl_mem  [enig_pkg::ALPHA];
    enig_pkg::letter_t wir_mem   [DEPTH];
    enig_pkg::letter_t inv_mem   [DEPTH];
    logic              notch_mem [DEPTH];

    logic [enig_pkg::ALPHA-1:0] plug_vld_reg;
    logic [enig_pkg::ALPHA-1:0] refl_vld_reg;
    logic [DEPTH-1:0]           wir_vld_reg;
    logic [DEPTH-1:0]           inv_vld_reg;
    logic [DEPTH-1:0]           notch_vld_reg;

    enig_pkg::letter_t plug_q_reg, refl_q_reg, wir_q_reg, inv_q_reg;
    enig_pkg::letter_t plug_id_reg, refl_id_reg, wir_id_reg, inv_id_reg;
    logic              notch_q_reg;
    logic              plug_hit_reg, refl_hit_reg, wir_hit_reg, inv_hit_reg, notch_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plug_vld_reg  <= '0;
            refl_vld_reg  <= '0;
            wir_vld_reg   <= '0;
            inv_vld_reg   <= '0;
            notch_vld_reg <= '0;
        end
        else
        begin
            if (req.plug_we)
            begin
                plug_vld_reg[req.plug_addr] <= 1'b1;
            end
            if (req.refl_we)
            begin
                refl_vld_reg[req.refl_addr] <= 1'b1;
            end
            if (req.wir_we)
            begin
                wir_vld_reg[wir_addr] <= 1'b1;
            end
            if (req.inv_we)
            begin
                inv_vld_reg[inv_addr] <= 1'b1;
            end
            if (req.notch_we)
            begin
                notch_vld_reg[notch_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.plug_we)
        begin
            plug_mem[req.plug_addr] <= req.plug_wdata;
        end
        if (req.refl_we)
        begin
            refl_mem[req.refl_addr] <= req.refl_wdata;
        end
        if (req.wir_we)
        begin
            wir_mem[wir_addr] <= req.wir_wdata;
        end
        if (req.inv_we)
        begin
            inv_mem[inv_addr] <= req.inv_wdata;
        end
        if (req.notch_we)
        begin
            notch_mem[notch_addr] <= req.notch_wdata;
        end

        plug_q_reg    <= plug_mem[req.plug_addr];
        plug_hit_reg  <= plug_vld_reg[req.plug_addr];
        plug_id_reg   <= req.plug_addr;
        refl_q_reg    <= refl_mem[req.refl_addr];
        refl_hit_reg  <= refl_vld_reg[req.refl_addr];
        refl_id_reg   <= req.refl_addr;
        wir_q_reg     <= wir_mem[wir_addr];
        wir_hit_reg   <= wir_vld_reg[wir_addr];
        wir_id_reg    <= req.wir_contact;
        inv_q_reg     <= inv_mem[inv_addr];
        inv_hit_reg   <= inv_vld_reg[inv_addr];
        inv_id_reg    <= req.inv_contact;
        notch_q_reg   <= notch_mem[notch_addr];
        notch_hit_reg <= notch_vld_reg[notch_addr];
    end

    // unwritten entries read as identity, notches as clear
    assign rsp.plug_rd  = plug_hit_reg  ? plug_q_reg : plug_id_reg;
    assign rsp.refl_rd  = refl_hit_reg  ? refl_q_reg : refl_id_reg;
    assign rsp.wir_rd   = wir_hit_reg   ? wir_q_reg  : wir_id_reg;
    assign rsp.inv_rd   = inv_hit_reg   ? inv_q_reg  : inv_id_reg;
    assign rsp.notch_rd = notch_hit_reg & notch_q_reg;

endmodule

// File: hdl/enig_ctrl.sv
// Sequencer: command decode, rotor stepping, letter path and output register.
module enig_ctrl
#(
    parameter int ROTOR_COUNT = enig_pkg::DEF_ROTOR_COUNT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  enig_pkg::cmd_t          command,
    input  enig_pkg::letter_t       letter,
    input  logic [2:0]              rotor_index,
    input  enig_pkg::letter_t       table_index,
    input  enig_pkg::letter_t       table_value,
    input  logic                    notch_flag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output enig_pkg::letter_t       cipher_letter,
    output logic                    letter_valid,
    output enig_pkg::enig_tbl_req_t req,
    output logic [$clog2(ROTOR_COUNT*enig_pkg::ALPHA)-1:0] wir_addr,
    output logic [$clog2(ROTOR_COUNT*enig_pkg::ALPHA)-1:0] inv_addr,
    output logic [$clog2(ROTOR_COUNT*enig_pkg::ALPHA)-1:0] notch_addr,
    input  enig_pkg::enig_tbl_rsp_t rsp
);

    localparam int AW = $clog2(ROTOR_COUNT * enig_pkg::ALPHA);
    localparam int KW = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_STEP, S_NOTCH, S_P1, S_P1C, S_FA, S_FB, S_R, S_RC,
        S_BA, S_BB, S_P2, S_P2C, S_PW1, S_PW2, S_RW1, S_RW2, S_WW,
        S_NW, S_POSW, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    enig_pkg::letter_t x_reg, x_next;
    enig_pkg::letter_t ti_reg, ti_next;
    enig_pkg::letter_t tv_reg, tv_next;
    logic              nf_reg, nf_next;
    logic              step_reg, step_next;
    logic              enc_reg, enc_next;
    enig_pkg::letter_t pos_reg [ROTOR_COUNT];
    enig_pkg::letter_t pos_next [ROTOR_COUNT];
    logic              m_valid_reg, m_valid_next;
    enig_pkg::letter_t m_letter_reg, m_letter_next;
    logic              m_flag_reg, m_flag_next;

    enig_pkg::letter_t am_a, am_b, am_sum;
    enig_pkg::letter_t pos_k, pos_neg;
    enig_pkg::letter_t wir_col, inv_col, notch_col;
    logic [AW-1:0]     rot_base;
    logic              idx_ok, rot_ok, accept;

    enig_addmod u_addmod
    (
        .a   (am_a),
        .b   (am_b),
        .sum (am_sum)
    );

    assign pos_k    = pos_reg[k_reg];
    assign pos_neg  = 5'(enig_pkg::ALPHA) - pos_k;
    assign rot_base = AW'(k_reg) * AW'(enig_pkg::ALPHA);

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign idx_ok        = (table_index < 5'(enig_pkg::ALPHA))
                           && (table_value < 5'(enig_pkg::ALPHA));
    assign rot_ok        = ({1'b0, rotor_index} < 4'(ROTOR_COUNT));
    assign out_valid     = m_valid_reg;
    assign cipher_letter = m_letter_reg;
    assign letter_valid  = m_flag_reg;

    // shared adder operands
    always_comb
    begin
        am_a = x_reg;
        am_b = '0;
        unique case (state_reg)
            S_STEP:
            begin
                am_a = pos_k;
                am_b = {4'b0, step_reg};
            end
            S_FA, S_BA:
            begin
                am_a = x_reg;
                am_b = pos_k;
            end
            S_FB:
            begin
                am_a = rsp.wir_rd;
                am_b = pos_neg;
            end
            S_BB:
            begin
                am_a = rsp.inv_rd;
                am_b = pos_neg;
            end
            default:
            begin
                am_a = x_reg;
                am_b = '0;
            end
        endcase
    end

    // table requests
    always_comb
    begin
        req             = '0;
        req.plug_addr   = x_reg;
        req.refl_addr   = x_reg;
        wir_col         = am_sum;
        inv_col         = am_sum;
        notch_col       = am_sum;
        unique case (state_reg)
            S_PW1:
            begin
                req.plug_we    = 1'b1;
                req.plug_addr  = ti_reg;
                req.plug_wdata = tv_reg;
            end
            S_PW2:
            begin
                req.plug_we    = 1'b1;
                req.plug_addr  = tv_reg;
                req.plug_wdata = ti_reg;
            end
            S_RW1:
            begin
                req.refl_we    = 1'b1;
                req.refl_addr  = ti_reg;
                req.refl_wdata = tv_reg;
            end
            S_RW2:
            begin
                req.refl_we    = 1'b1;
                req.refl_addr  = tv_reg;
                req.refl_wdata = ti_reg;
            end
            S_WW:
            begin
                req.wir_we    = 1'b1;
                req.wir_wdata = tv_reg;
                wir_col       = ti_reg;
                req.inv_we    = 1'b1;
                req.inv_wdata = ti_reg;
                inv_col       = tv_reg;
            end
            S_NW:
            begin
                req.notch_we    = 1'b1;
                req.notch_wdata = nf_reg;
                notch_col       = ti_reg;
            end
            default:
            begin
            end
        endcase
        req.wir_contact = wir_col;
        req.inv_contact = inv_col;
    end

    assign wir_addr   = rot_base + AW'(wir_col);
    assign inv_addr   = rot_base + AW'(inv_col);
    assign notch_addr = rot_base + AW'(notch_col);

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        x_next        = x_reg;
        ti_next       = ti_reg;
        tv_next       = tv_reg;
        nf_next       = nf_reg;
        step_next     = step_reg;
        enc_next      = enc_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        m_letter_next = m_letter_reg;
        m_flag_next   = m_flag_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next     = letter;
                    ti_next    = table_index;
                    tv_next    = table_value;
                    nf_next    = notch_flag;
                    k_next     = KW'(rotor_index);
                    enc_next   = 1'b0;
                    state_next = S_DONE;
                    unique case (command)
                        enig_pkg::CMD_ENCRYPT:
                        begin
                            if (letter < 5'(enig_pkg::ALPHA))
                            begin
                                k_next     = KW'(ROTOR_COUNT - 1);
                                step_next  = 1'b1;
                                state_next = S_STEP;
                            end
                        end
                        enig_pkg::CMD_PLUG:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_PW1;
                            end
                        end
                        enig_pkg::CMD_REFL:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_RW1;
                            end
                        end
                        enig_pkg::CMD_WIRE:
                        begin
                            if (idx_ok && rot_ok)
                            begin
                                state_next = S_WW;
                            end
                        end
                        enig_pkg::CMD_NOTCH:
                        begin
                            if ((table_index < 5'(enig_pkg::ALPHA)) && rot_ok)
                            begin
                                state_next = S_NW;
                            end
                        end
                        enig_pkg::CMD_POS:
                        begin
                            if ((table_value < 5'(enig_pkg::ALPHA)) && rot_ok)
                            begin
                                state_next = S_POSW;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                pos_next[k_reg] = am_sum;
                state_next      = S_NOTCH;
            end
            S_NOTCH:
            begin
                step_next = rsp.notch_rd;
                if (k_reg == '0)
                begin
                    state_next = S_P1;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_STEP;
                end
            end
            S_P1:
            begin
                state_next = S_P1C;
            end
            S_P1C:
            begin
                x_next     = rsp.plug_rd;
                k_next     = KW'(ROTOR_COUNT - 1);
                state_next = S_FA;
            end
            S_FA:
            begin
                state_next = S_FB;
            end
            S_FB:
            begin
                x_next = am_sum;
                if (k_reg == '0)
                begin
                    state_next = S_R;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_FA;
                end
            end
            S_R:
            begin
                state_next = S_RC;
            end
            S_RC:
            begin
                x_next     = rsp.refl_rd;
                k_next     = '0;
                state_next = S_BA;
            end
            S_BA:
            begin
                state_next = S_BB;
            end
            S_BB:
            begin
                x_next = am_sum;
                if (k_reg == KW'(ROTOR_COUNT - 1))
                begin
                    state_next = S_P2;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_BA;
                end
            end
            S_P2:
            begin
                state_next = S_P2C;
            end
            S_P2C:
            begin
                x_next     = rsp.plug_rd;
                enc_next   = 1'b1;
                state_next = S_DONE;
            end
            S_PW1:
            begin
                state_next = S_PW2;
            end
            S_RW1:
            begin
                state_next = S_RW2;
            end
            S_PW2, S_RW2, S_WW, S_NW:
            begin
                state_next = S_DONE;
            end
            S_POSW:
            begin
                pos_next[k_reg] = tv_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || out_ready)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = enc_reg ? x_reg : '0;
                    m_flag_next   = enc_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < ROTOR_COUNT; i++)
            begin
                pos_reg[i] <= '0;
            end
            k_reg        <= '0;
            x_reg        <= '0;
            ti_reg       <= '0;
            tv_reg       <= '0;
            nf_reg       <= 1'b0;
            step_reg     <= 1'b0;
            enc_reg      <= 1'b0;
            m_letter_reg <= '0;
            m_flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            x_reg        <= x_next;
            ti_reg       <= ti_next;
            tv_reg       <= tv_next;
            nf_reg       <= nf_next;
            step_reg     <= step_next;
            enc_reg      <= enc_next;
            m_letter_reg <= m_letter_next;
            m_flag_reg   <= m_flag_next;
        end
    end

endmodule

// File: tb/sv/enigma_rotor_cipher_tb.sv
// Testbench for the rotor cipher: directed table, then random load and encrypt traffic.
`timescale 1ns / 1ps

module enigma_rotor_cipher_tb;

    localparam int             NR          = enig_pkg::DEF_ROTOR_COUNT;
    localparam int             RAND_ITEMS  = 1400;
    localparam int             CALM_ITEMS  = 150;
    localparam int             WATCH_LIMIT = 2000;
    localparam int             DRAIN_WAIT  = 60;
    localparam enig_pkg::cmd_t CMD_SPARE6  = 3'd6;
    localparam enig_pkg::cmd_t CMD_SPARE7  = 3'd7;

    typedef struct {
        enig_pkg::cmd_t    cmd;
        enig_pkg::letter_t letter;
        logic [2:0]        rot;
        enig_pkg::letter_t ti;
        enig_pkg::letter_t tv;
        logic              nf;
        bit                typed;
        enig_pkg::letter_t exp_letter;
        logic              exp_valid;
    } cipher_cmd_t;

    typedef struct {
        enig_pkg::letter_t letter;
        logic              valid;
    } cipher_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;

    // predictor state
    enig_pkg::letter_t plug_map [enig_pkg::ALPHA];
    enig_pkg::letter_t refl_map [enig_pkg::ALPHA];
    enig_pkg::letter_t wire_map [NR][enig_pkg::ALPHA];
    enig_pkg::letter_t inv_map  [NR][enig_pkg::ALPHA];
    bit                notch_map[NR][enig_pkg::ALPHA];
    enig_pkg::letter_t rotor_pos[NR];

    cipher_cmd_t stim_q[$];
    cipher_out_t cipher_expected_q[$];
    int          deck[enig_pkg::ALPHA];

    bit                in_take = 1'b0;
    bit                out_take = 1'b0;
    enig_pkg::letter_t out_letter;
    logic              out_valid;
    bit                calm = 1'b0;
    int                idle_cycles = 0;
    int                errors = 0;
    int                n_letters = 0;
    int                n_others = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    enigma_rotor_cipher #(.ROTOR_COUNT(NR)) i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic reset_tables();
        int i;
        int r;
        for (i = 0; i < enig_pkg::ALPHA; i++)
        begin
            plug_map[i] = enig_pkg::letter_t'(i);
            refl_map[i] = enig_pkg::letter_t'(i);
            for (r = 0; r < NR; r++)
            begin
                wire_map[r][i]  = enig_pkg::letter_t'(i);
                inv_map[r][i]   = enig_pkg::letter_t'(i);
                notch_map[r][i] = 1'b0;
            end
        end
        for (r = 0; r < NR; r++)
            rotor_pos[r] = '0;
    endtask

    function automatic int rotor_pass(input bit back, input int r, input int x);
        int p;
        int y;
        p = rotor_pos[r];
        y = back ? inv_map[r][(x + p) % enig_pkg::ALPHA]
                 : wire_map[r][(x + p) % enig_pkg::ALPHA];
        return (y + enig_pkg::ALPHA - p) % enig_pkg::ALPHA;
    endfunction

    function automatic cipher_out_t rotor_machine_step(input cipher_cmd_t c);
        cipher_out_t o;
        int          x;
        int          k;
        bit          idx_ok;
        bit          rot_ok;
        o.letter = '0;
        o.valid  = 1'b0;
        idx_ok   = (c.ti < enig_pkg::ALPHA) && (c.tv < enig_pkg::ALPHA);
        rot_ok   = c.rot < NR;
        case (c.cmd)
            enig_pkg::CMD_ENCRYPT:
            begin
                if (c.letter < enig_pkg::ALPHA)
                begin
                    rotor_pos[NR-1] = enig_pkg::letter_t'((int'(rotor_pos[NR-1]) + 1)
                                                          % enig_pkg::ALPHA);
                    for (k = NR - 2; k >= 0; k--)
                        if (notch_map[k+1][rotor_pos[k+1]])
                            rotor_pos[k] = enig_pkg::letter_t'((int'(rotor_pos[k]) + 1)
                                                               % enig_pkg::ALPHA);
                    x = plug_map[c.letter];
                    for (k = NR - 1; k >= 0; k--)
                        x = rotor_pass(1'b0, k, x);
                    x = refl_map[x];
                    for (k = 0; k < NR; k++)
                        x = rotor_pass(1'b1, k, x);
                    o.letter = plug_map[x];
                    o.valid  = 1'b1;
                end
            end
            enig_pkg::CMD_PLUG:
            begin
                if (idx_ok)
                begin
                    plug_map[c.ti] = c.tv;
                    plug_map[c.tv] = c.ti;
                end
            end
            enig_pkg::CMD_WIRE:
            begin
                if (idx_ok && rot_ok)
                begin
                    wire_map[c.rot][c.ti] = c.tv;
                    inv_map[c.rot][c.tv]  = c.ti;
                end
            end
            enig_pkg::CMD_REFL:
            begin
                if (idx_ok)
                begin
                    refl_map[c.ti] = c.tv;
                    refl_map[c.tv] = c.ti;
                end
            end
            enig_pkg::CMD_NOTCH:
            begin
                if (c.ti < enig_pkg::ALPHA && rot_ok)
                    notch_map[c.rot][c.ti] = c.nf;
            end
            enig_pkg::CMD_POS:
            begin
                if (c.tv < enig_pkg::ALPHA && rot_ok)
                    rotor_pos[c.rot] = c.tv;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic add_row(input enig_pkg::cmd_t cmd, input int letter, input int rot,
                           input int ti, input int tv, input int nf, input bit typed,
                           input int exp_letter, input int exp_valid);
        cipher_cmd_t c;
        c.cmd        = cmd;
        c.letter     = enig_pkg::letter_t'(letter);
        c.rot        = 3'(rot);
        c.ti         = enig_pkg::letter_t'(ti);
        c.tv         = enig_pkg::letter_t'(tv);
        c.nf         = 1'(nf);
        c.typed      = typed;
        c.exp_letter = enig_pkg::letter_t'(exp_letter);
        c.exp_valid  = 1'(exp_valid);
        stim_q.insert(stim_q.size(), c);
    endtask

    task automatic add_load(input enig_pkg::cmd_t cmd, input int rot, input int ti,
                            input int tv, input int nf);
        add_row(cmd, $urandom_range(0, 31), rot, ti, tv, nf, 1'b0, 0, 0);
    endtask

    task automatic add_letter(input int letter);
        add_row(enig_pkg::CMD_ENCRYPT, letter, $urandom_range(0, 7), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 1), 1'b0, 0, 0);
    endtask

    task automatic shuffle_deck();
        int i;
        int j;
        int t;
        for (i = 0; i < enig_pkg::ALPHA; i++)
            deck[i] = i;
        for (i = enig_pkg::ALPHA - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = deck[i];
            deck[i] = deck[j];
            deck[j] = t;
        end
    endtask

    task automatic rewire_rotor(input int r);
        int i;
        shuffle_deck();
        for (i = 0; i < enig_pkg::ALPHA; i++)
            add_load(enig_pkg::CMD_WIRE, r, i, deck[i], $urandom_range(0, 1));
    endtask

    task automatic rebuild_reflector();
        int i;
        shuffle_deck();
        for (i = 0; i < enig_pkg::ALPHA / 2; i++)
            add_load(enig_pkg::CMD_REFL, $urandom_range(0, 7), deck[2*i], deck[2*i+1],
                     $urandom_range(0, 1));
    endtask

    task automatic build_directed();
        // reset state is identity throughout, so plain letters come straight back
        add_row(enig_pkg::CMD_ENCRYPT, 0, 0, 0, 0, 0, 1'b1, 0, 1);
        add_row(enig_pkg::CMD_ENCRYPT, 25, 7, 31, 31, 1, 1'b1, 25, 1);
        add_row(enig_pkg::CMD_ENCRYPT, 26, 0, 0, 0, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_ENCRYPT, 31, 0, 0, 0, 0, 1'b1, 0, 0);
        add_row(CMD_SPARE6, 31, 7, 31, 31, 1, 1'b1, 0, 0);
        add_row(CMD_SPARE7, 0, 0, 0, 0, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_PLUG, 0, 0, 0, 25, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_ENCRYPT, 0, 0, 0, 0, 0, 1'b0, 0, 0);
        add_row(enig_pkg::CMD_PLUG, 0, 0, 31, 31, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_REFL, 0, 0, 0, 25, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_REFL, 0, 0, 31, 0, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_ENCRYPT, 3, 0, 0, 0, 0, 1'b0, 0, 0);
        add_row(enig_pkg::CMD_WIRE, 0, 2, 0, 25, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_WIRE, 0, 7, 25, 0, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_WIRE, 0, 0, 25, 31, 0, 1'b1, 0, 0);
        // wiring left non-permutation: two contacts onto 0
        add_row(enig_pkg::CMD_WIRE, 0, 0, 25, 0, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_NOTCH, 0, 2, 0, 0, 1, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_NOTCH, 0, 1, 1, 0, 1, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_NOTCH, 0, 3, 0, 0, 1, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_NOTCH, 0, 0, 26, 0, 1, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_POS, 0, 2, 0, 25, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_POS, 0, 1, 0, 31, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_POS, 0, 0, 31, 3, 0, 1'b1, 0, 0);
        // right rotor wraps onto its notch, middle steps onto its own, left steps
        add_row(enig_pkg::CMD_ENCRYPT, 13, 0, 0, 0, 0, 1'b0, 0, 0);
        add_row(enig_pkg::CMD_ENCRYPT, 5, 7, 31, 31, 1, 1'b0, 0, 0);
        add_row(enig_pkg::CMD_NOTCH, 0, 2, 0, 0, 0, 1'b1, 0, 0);
        add_row(enig_pkg::CMD_ENCRYPT, 25, 0, 0, 0, 0, 1'b0, 0, 0);
    endtask

    task automatic build_random();
        int target;
        int r;
        int i;
        int n;
        target = stim_q.size() + RAND_ITEMS;
        for (r = 0; r < NR; r++)
            rewire_rotor(r);
        rebuild_reflector();
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++)
        begin
            shuffle_deck();
            add_load(enig_pkg::CMD_PLUG, $urandom_range(0, 7), deck[0], deck[1],
                     $urandom_range(0, 1));
        end
        for (r = 0; r < NR; r++)
        begin
            add_load(enig_pkg::CMD_NOTCH, r, $urandom_range(0, enig_pkg::ALPHA - 1), 0, 1);
            add_load(enig_pkg::CMD_POS, r, $urandom_range(0, 31),
                     $urandom_range(0, enig_pkg::ALPHA - 1), 0);
        end
        while (stim_q.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                rewire_rotor($urandom_range(0, NR - 1));
            else if (r < 5)
                rebuild_reflector();
            else if (r < 10)
                add_load(enig_pkg::CMD_PLUG, $urandom_range(0, 7),
                         $urandom_range(0, enig_pkg::ALPHA - 1),
                         $urandom_range(0, enig_pkg::ALPHA - 1), $urandom_range(0, 1));
            else if (r < 15)
                add_load(enig_pkg::CMD_NOTCH, $urandom_range(0, NR - 1),
                         $urandom_range(0, enig_pkg::ALPHA - 1),
                         $urandom_range(0, 31), $urandom_range(0, 1));
            else if (r < 19)
                add_load(enig_pkg::CMD_POS, $urandom_range(0, NR - 1), $urandom_range(0, 31),
                         $urandom_range(0, enig_pkg::ALPHA - 1), $urandom_range(0, 1));
            else if (r < 24)
                add_load(enig_pkg::CMD_WIRE, $urandom_range(0, NR - 1),
                         $urandom_range(0, enig_pkg::ALPHA - 1),
                         $urandom_range(0, enig_pkg::ALPHA - 1), $urandom_range(0, 1));
            else if (r < 32)
                add_row(enig_pkg::cmd_t'($urandom_range(0, 7)), $urandom_range(0, 31),
                        $urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 1), 1'b0, 0, 0);
            else
            begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++)
                    add_letter($urandom_range(0, enig_pkg::ALPHA - 1));
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(negedge clk)
    begin
        in_take    = (s_axis_tvalid === 1'b1) && (s_axis_tready === 1'b1);
        out_take   = (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
        out_letter = m_axis_tdata[4:0];
        out_valid  = m_axis_tuser;
    end

    // result checking and sink backpressure
    always @(posedge clk)
    begin : sink
        cipher_out_t e;
        bit          rdy;
        int          stall_left;
        int          sink_mode;
        int          sink_cycle;
        if (out_take)
        begin
            if (cipher_expected_q.size() == 0)
                report_mismatch($sformatf("result %0d/%0d with none expected", out_letter,
                                          out_valid));
            else
            begin
                e = cipher_expected_q.pop_front();
                if (out_letter !== e.letter)
                    report_mismatch($sformatf("cipher_letter %0d, expected %0d", out_letter,
                                              e.letter));
                if (out_valid !== e.valid)
                    report_mismatch($sformatf("letter_valid %0b, expected %0b", out_valid,
                                              e.valid));
                if (e.valid)
                    n_letters++;
                else
                    n_others++;
            end
        end
        idle_cycles <= (in_take || out_take) ? 0 : idle_cycles + 1;
        if (sink_cycle % 200 == 0)
            sink_mode = $urandom_range(0, 2);
        sink_cycle++;
        rdy = 1'b1;
        if (stall_left > 0)
        begin
            stall_left--;
            rdy = 1'b0;
        end
        else if (!calm && sink_mode != 0 && $urandom_range(0, sink_mode == 1 ? 9 : 2) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            rdy        = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCH_LIMIT)
            @(posedge clk);
        $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                 WATCH_LIMIT, cipher_expected_q.size());
        $display("enigma_rotor_cipher_tb: FAIL");
        $finish;
    end

    initial
    begin : source
        int          k;
        int          calm_from;
        int          src_mode;
        cipher_cmd_t c;
        cipher_out_t p;
        cipher_out_t e;
        reset_tables();
        build_directed();
        build_random();
        calm_from = stim_q.size() - CALM_ITEMS;
        src_mode  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (k = 0; k < stim_q.size(); k++)
        begin
            c = stim_q[k];
            if (k % 50 == 0)
                src_mode = $urandom_range(0, 2);
            if (k == calm_from)
                calm <= 1'b1;
            if (k < calm_from && src_mode != 0 &&
                $urandom_range(0, src_mode == 1 ? 9 : 2) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {5'b0, c.nf, c.tv, c.ti, c.rot, c.letter};
            s_axis_tuser  <= c.cmd;
            do
                @(posedge clk);
            while (!in_take);
            p = rotor_machine_step(c);
            if (c.typed)
            begin
                e.letter = c.exp_letter;
                e.valid  = c.exp_valid;
            end
            else
                e = p;
            cipher_expected_q.insert(cipher_expected_q.size(), e);
        end
        s_axis_tvalid <= 1'b0;
        while (cipher_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("ran %0d items: %0d enciphered letters, %0d loads and rejected items",
                 stim_q.size(), n_letters, n_others);
        $display("rotor rewires, reflector rebuilds, plug, notch and position loads, noise");
        if (errors == 0 && cipher_expected_q.size() == 0)
            $display("enigma_rotor_cipher_tb: PASS");
        else
            $display("enigma_rotor_cipher_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/enig_pkg.sv
hdl/enig_addmod.sv
hdl/enig_tables.sv
hdl/enig_ctrl.sv
hdl/enigma_rotor_cipher.sv
tb/sv/enigma_rotor_cipher_tb.sv
